FILE: rtl/core/pqws_pkg.sv
// Shared constants, types and register map of the PQ window lookup score core.
package pqws_pkg;

  // Parameter defaults
  localparam int DEF_MAX_SUBQ      = 8;
  localparam int DEF_MAX_CODE_BITS = 8;
  localparam int DEF_MAX_WINDOW    = 64;

  // Fixed field widths
  localparam int NODE_W  = 64;
  localparam int LUT_W   = 16;
  localparam int SCORE_W = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register widths
  localparam int CB_W  = 4;
  localparam int NSQ_W = 4;
  localparam int WIN_W = 7;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_CODE_BITS  = 2'd0;
  localparam logic [1:0] REG_SUBQ       = 2'd1;
  localparam logic [1:0] REG_WINDOW_LEN = 2'd2;

  // Reset values
  localparam logic [CB_W-1:0]  RST_CODE_BITS  = 4'd8;
  localparam logic [NSQ_W-1:0] RST_SUBQ       = 4'd8;
  localparam logic [WIN_W-1:0] RST_WINDOW_LEN = 7'd1;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SCORE = 1'b1;

  typedef struct packed {
    logic [CB_W-1:0]  code_bits;
    logic [NSQ_W-1:0] subquantizers;
    logic [WIN_W-1:0] window_len;
  } pqws_cfg_t;

  typedef struct packed {
    logic s1_valid;   // lookup data in the RAM output registers
    logic s2_valid;   // lane sum registered, waiting for the accumulator
  } pqws_pipe_t;

endpackage

FILE: rtl/core/pqws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pqws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/pqws_lookup.sv
// Banked similarity table: code unpack, per-subquantizer lookup and lane sum.
module pqws_lookup import pqws_pkg::*; #(
  parameter int MAX_SUBQ      = DEF_MAX_SUBQ,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
  localparam int SUM_W        = LUT_W + $clog2(MAX_SUBQ) + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  pqws_cfg_t          cfg,
  input  logic               stall,
  input  logic               score_fire,
  input  logic               load_fire,
  input  logic [NODE_W-1:0]  query_codes,
  input  logic [NODE_W-1:0]  target_codes,
  input  logic [2:0]         load_subq,
  input  logic [7:0]         load_left,
  input  logic [7:0]         load_right,
  input  logic [LUT_W-1:0]   load_value,
  output pqws_pipe_t         pipe,
  output logic [SUM_W-1:0]   lane_sum
);

  localparam int CB    = MAX_CODE_BITS;
  localparam int AW    = 2 * CB;
  localparam int DEPTH = 1 << AW;
  localparam int NPAIR = (MAX_SUBQ + 1) / 2;

  logic [CB_W-1:0]     cb_eff;
  logic [NSQ_W:0]      nsq_eff;
  logic [CB-1:0]       code_mask;
  logic                load_ok;
  logic [AW-1:0]       waddr;
  logic [LUT_W-1:0]    rdata [MAX_SUBQ];
  logic [MAX_SUBQ-1:0] active;
  logic [MAX_SUBQ-1:0] s1_mask;
  logic [SUM_W-1:0]    lane_val [2*NPAIR];
  logic [SUM_W-1:0]    pair_sum [NPAIR];
  logic [SUM_W-1:0]    tree_sum;
  logic                s1_valid;
  logic                s2_valid;

  // Saturate the registers to their usable ranges
  always_comb begin
    if (cfg.code_bits == '0) begin
      cb_eff = CB_W'(1);
    end else if (cfg.code_bits > CB_W'(MAX_CODE_BITS)) begin
      cb_eff = CB_W'(MAX_CODE_BITS);
    end else begin
      cb_eff = cfg.code_bits;
    end
    if (cfg.subquantizers == '0) begin
      nsq_eff = (NSQ_W+1)'(1);
    end else if ({1'b0, cfg.subquantizers} > (NSQ_W+1)'(MAX_SUBQ)) begin
      nsq_eff = (NSQ_W+1)'(MAX_SUBQ);
    end else begin
      nsq_eff = {1'b0, cfg.subquantizers};
    end
  end

  assign code_mask = ~({CB{1'b1}} << cb_eff);

  // Out-of-range loads are dropped
  assign load_ok = (32'(load_subq) < MAX_SUBQ) && (32'(load_left) < (1 << CB))
                && (32'(load_right) < (1 << CB));
  assign waddr   = {load_left[CB-1:0], load_right[CB-1:0]};

  for (genvar s = 0; s < MAX_SUBQ; s++) begin : g_bank
    logic [7:0]        offset;
    logic [NODE_W-1:0] left_sh;
    logic [NODE_W-1:0] right_sh;
    logic [CB-1:0]     lcode;
    logic [CB-1:0]     rcode;

    // Bit offset of this lane's code; shifts past bit 63 read zero
    assign offset   = 8'(s) * 8'(cb_eff);
    assign left_sh  = query_codes >> offset;
    assign right_sh = target_codes >> offset;
    assign lcode    = left_sh[CB-1:0] & code_mask;
    assign rcode    = right_sh[CB-1:0] & code_mask;
    assign active[s] = (NSQ_W+1)'(s) < nsq_eff;

    pqws_ram #(
      .WIDTH (LUT_W),
      .DEPTH (DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (load_fire && load_ok && (32'(load_subq) == s)),
      .waddr (waddr),
      .wdata (load_value),
      .re    (score_fire),
      .raddr ({lcode, rcode}),
      .rdata (rdata[s])
    );
  end

  // Lane sum: pair adds, then a sum of the NPAIR pair sums
  always_comb begin
    for (int i = 0; i < 2 * NPAIR; i++) begin
      lane_val[i] = '0;
    end
    for (int i = 0; i < MAX_SUBQ; i++) begin
      lane_val[i] = s1_mask[i] ? SUM_W'(signed'(rdata[i])) : '0;
    end
    for (int p = 0; p < NPAIR; p++) begin
      pair_sum[p] = lane_val[2*p] + lane_val[2*p+1];
    end
    tree_sum = '0;
    for (int p = 0; p < NPAIR; p++) begin
      tree_sum = tree_sum + pair_sum[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= score_fire;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      if (score_fire) begin
        s1_mask <= active;
      end
      lane_sum <= tree_sum;
    end
  end

  assign pipe.s1_valid = s1_valid;
  assign pipe.s2_valid = s2_valid;

endmodule

FILE: rtl/core/pqws_accum.sv
// Window accumulator, position counter and score output register.
module pqws_accum import pqws_pkg::*; #(
  parameter int MAX_SUBQ   = DEF_MAX_SUBQ,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int SUM_W     = LUT_W + $clog2(MAX_SUBQ) + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pqws_cfg_t                 cfg,
  input  logic                      sum_valid,
  input  logic [SUM_W-1:0]          lane_sum,
  output logic                      stall,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SCORE_W-1:0] score
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  logic [CNT_W-1:0]   wl_eff;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_inc;
  logic [SCORE_W-1:0] running_sum;
  logic [SCORE_W-1:0] sum_next;
  logic               emit;
  logic               take;

  always_comb begin
    if (cfg.window_len == '0) begin
      wl_eff = CNT_W'(1);
    end else if (9'(cfg.window_len) > 9'(MAX_WINDOW)) begin
      wl_eff = CNT_W'(MAX_WINDOW);
    end else begin
      wl_eff = CNT_W'(cfg.window_len);
    end
  end

  assign count_inc = count + CNT_W'(1);
  assign emit      = count_inc >= wl_eff;
  assign sum_next  = running_sum + SCORE_W'(signed'(lane_sum));
  // Only an emitting position waits on a full output register
  assign stall     = sum_valid && emit && out_valid && !out_ready;
  assign take      = sum_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take && emit) begin
        running_sum <= '0;
        count       <= '0;
        out_valid   <= 1'b1;
      end else begin
        if (take) begin
          running_sum <= sum_next;
          count       <= count_inc;
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      score <= signed'(sum_next);
    end
  end

endmodule

FILE: rtl/core/pq_window_lookup_score_core.sv
// Top level of the PQ window lookup score core: config registers and pipeline.
//
// Scores windows of product-quantized node pairs against a loaded similarity
// table. An item with op = load writes one signed Q8.8 entry at (load_subq,
// load_left, load_right); loads beyond the table are dropped and never give
// a result. An item with op = score unpacks one code per active subquantizer
// from query_codes and target_codes (LSB first, code_bits each, bits past 63
// read zero), looks up all of them in parallel and adds them to a running
// Q24.8 sum; once window_len positions are in, the sum goes out on score and
// restarts from zero. The table is one RAM bank per subquantizer, each
// 2^(2*MAX_CODE_BITS) x 16, with one write and one read port and a registered
// read. Its contents are undefined until loaded: there is no clearing pass,
// and scoring an entry never loaded returns garbage. Items are taken one per
// cycle while in_ready is high, loads and scores freely mixed; a load is
// written at its accept edge, so a score in the very next cycle already sees
// it. A window-closing score reads the RAM at its accept edge, then passes
// through the lane sum register and is accumulated into the output register; a
// stall holds it. in_ready drops only while a window-closing position sits in
// front of an output register still holding an untaken score. Registers
// (APB, 32-bit, byte address 4*index): code_bits at 0x0 (reset 8),
// subquantizers at 0x4 (reset 8), window_len at 0x8 (reset 1); out-of-range
// values are kept as written and saturated at use. Write them only while the
// core is idle.
module pq_window_lookup_score_core import pqws_pkg::*; #(
  parameter int MAX_SUBQ      = DEF_MAX_SUBQ,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
  parameter int MAX_WINDOW    = DEF_MAX_WINDOW
) (
  input  logic                      clk,
  input  logic                      rst,
  // input items
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [NODE_W-1:0]         query_codes,
  input  logic [NODE_W-1:0]         target_codes,
  input  logic [2:0]                load_subq,
  input  logic [7:0]                load_left,
  input  logic [7:0]                load_right,
  input  logic signed [LUT_W-1:0]   load_value,
  // result items
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SCORE_W-1:0] score,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int SUM_W = LUT_W + $clog2(MAX_SUBQ) + 1;

  pqws_cfg_t        cfg;
  pqws_pipe_t       pipe;
  logic             stall;
  logic             accept;
  logic             score_fire;
  logic             load_fire;
  logic             cfg_wr;
  logic [SUM_W-1:0] lane_sum;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_bits     <= RST_CODE_BITS;
      cfg.subquantizers <= RST_SUBQ;
      cfg.window_len    <= RST_WINDOW_LEN;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CODE_BITS:  cfg.code_bits     <= pwdata[CB_W-1:0];
        REG_SUBQ:       cfg.subquantizers <= pwdata[NSQ_W-1:0];
        REG_WINDOW_LEN: cfg.window_len    <= pwdata[WIN_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CODE_BITS:  prdata = PDATA_W'(cfg.code_bits);
      REG_SUBQ:       prdata = PDATA_W'(cfg.subquantizers);
      REG_WINDOW_LEN: prdata = PDATA_W'(cfg.window_len);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input handshake: the whole pipe freezes on a blocked emit
  // ---------------------------------------------------------------------
  assign in_ready   = !stall;
  assign accept     = in_valid && in_ready;
  assign score_fire = accept && (op == OP_SCORE);
  assign load_fire  = accept && (op == OP_LOAD);

  pqws_lookup #(
    .MAX_SUBQ      (MAX_SUBQ),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_lookup (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .stall        (stall),
    .score_fire   (score_fire),
    .load_fire    (load_fire),
    .query_codes  (query_codes),
    .target_codes (target_codes),
    .load_subq    (load_subq),
    .load_left    (load_left),
    .load_right   (load_right),
    .load_value   (load_value),
    .pipe         (pipe),
    .lane_sum     (lane_sum)
  );

  pqws_accum #(
    .MAX_SUBQ   (MAX_SUBQ),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sum_valid (pipe.s2_valid),
    .lane_sum  (lane_sum),
    .stall     (stall),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .score     (score)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Backpressure only with a held result that is not being taken
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a blocked output");

  // A stall always has a position waiting in the accumulate stage
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    stall |-> pipe.s2_valid)
    else $error("stall with empty accumulate stage");

  // Every accepted score enters the lookup stage
  a_score_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == OP_SCORE)) |=> pipe.s1_valid)
    else $error("accepted score lost before lookup");

  // A stalled lookup stage keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (stall && pipe.s1_valid) |=> pipe.s1_valid)
    else $error("lookup stage dropped an item under stall");

endmodule
